/* hdl/eikonal_voxel_update_defines.svh */
// Assertion macros shared by the eikonal voxel update block.
`ifndef EIKONAL_VOXEL_UPDATE_DEFINES_SVH
`define EIKONAL_VOXEL_UPDATE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EVU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EVU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/evu_pkg.sv */
// Shared types, widths and helper functions of the eikonal voxel update block.
`timescale 1ns / 1ps

package evu_pkg;

  localparam int unsigned DistW     = 32;
  localparam int unsigned WgtW      = 32;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumNbrs   = 6;
  localparam int unsigned SumW      = 34;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned BW        = 66;
  localparam int unsigned PairW     = 128;
  localparam int unsigned PairSumW  = 130;
  localparam int unsigned DiscShift = 48;
  localparam int unsigned DiscW     = 82;
  localparam int unsigned RootW     = 41;
  localparam int unsigned NumW      = 67;
  localparam int unsigned QuotW     = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [WgtW-1:0]  WgtReset = 32'd65536;
  localparam logic [ProdW-1:0] OneQ32   = 64'h0000_0001_0000_0000;
  localparam logic [ProdW:0]   OneQ64   = {1'b1, 64'h0};

  typedef enum logic [1:0] {
    StatusUpdated     = 2'd0,
    StatusNoNeighbour = 2'd1,
    StatusNegDisc     = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvSqSpacingX = 2'd0,
    CfgInvSqSpacingY = 2'd1,
    CfgInvSqSpacingZ = 2'd2
  } cfg_idx_e;

  typedef logic [1:0] axis_t;
  typedef logic [NumAxes-1:0][WgtW-1:0]  weights_t;
  typedef logic [NumAxes-1:0][DistW-1:0] phi_t;

  // One classified neighbour set, as handed from the front end to the solver.
  typedef struct packed {
    phi_t               phi;
    logic [NumAxes-1:0] used;
  } cand_t;

  function automatic logic [DistW-1:0] abs_diff(input logic [DistW-1:0] a,
                                                input logic [DistW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [ProdW-1:0] mul_u32(input logic [31:0] a, input logic [31:0] b);
    return {32'h0, a} * {32'h0, b};
  endfunction

  // Axis pairs in the order (x,y), (x,z), (y,z).
  function automatic axis_t pair_lo(input axis_t p);
    axis_t r;
    case (p)
      2'd0:    r = 2'd0;
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic axis_t pair_hi(input axis_t p);
    axis_t r;
    case (p)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

/* hdl/evu_if.sv */
// Valid/ready channel interfaces of the eikonal voxel update block.
`timescale 1ns / 1ps

interface evu_in_if;
  logic                     valid;
  logic                     ready;
  logic [evu_pkg::DistW-1:0] dist_x_plus;
  logic [evu_pkg::DistW-1:0] dist_x_minus;
  logic [evu_pkg::DistW-1:0] dist_y_plus;
  logic [evu_pkg::DistW-1:0] dist_y_minus;
  logic [evu_pkg::DistW-1:0] dist_z_plus;
  logic [evu_pkg::DistW-1:0] dist_z_minus;
  logic                     accepted_x_plus;
  logic                     accepted_x_minus;
  logic                     accepted_y_plus;
  logic                     accepted_y_minus;
  logic                     accepted_z_plus;
  logic                     accepted_z_minus;

  modport source (
    output valid, dist_x_plus, dist_x_minus, dist_y_plus, dist_y_minus,
           dist_z_plus, dist_z_minus, accepted_x_plus, accepted_x_minus,
           accepted_y_plus, accepted_y_minus, accepted_z_plus, accepted_z_minus,
    input  ready
  );
  modport sink (
    input  valid, dist_x_plus, dist_x_minus, dist_y_plus, dist_y_minus,
           dist_z_plus, dist_z_minus, accepted_x_plus, accepted_x_minus,
           accepted_y_plus, accepted_y_minus, accepted_z_plus, accepted_z_minus,
    output ready
  );
endinterface

interface evu_out_if;
  logic                      valid;
  logic                      ready;
  logic [evu_pkg::DistW-1:0] new_distance;
  logic [1:0]                status;

  modport source (output valid, new_distance, status, input ready);
  modport sink (input valid, new_distance, status, output ready);
endinterface

interface evu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [evu_pkg::CfgIdxW-1:0] index;
  logic [evu_pkg::WgtW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/evu_queue.sv */
// Small first-in first-out queue between the classifier and the solver.
`timescale 1ns / 1ps

module evu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  evu_pkg::cand_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  output evu_pkg::cand_t data_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  evu_pkg::cand_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/evu_front.sv */
// Front end: takes a neighbour set, picks per-axis minima and prunes axes.
`timescale 1ns / 1ps

module evu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  evu_in_if.sink            in_i,
  input  evu_pkg::weights_t weights_i,
  output logic              cand_valid_o,
  output evu_pkg::cand_t    cand_o,
  input  logic              cand_ready_i
);

  logic adv;

  // Stage 1: the registered request.
  logic                                       s1_valid_q;
  logic [evu_pkg::NumNbrs-1:0][evu_pkg::DistW-1:0] s1_dist_q;
  logic [evu_pkg::NumNbrs-1:0]                s1_acc_q;

  evu_pkg::phi_t               s1_phi;
  logic [evu_pkg::NumAxes-1:0] s1_used;
  evu_pkg::axis_t              s1_mx, s1_i, s1_j;

  // Stage 2: three-axis test terms.
  logic                         s2_valid_q;
  evu_pkg::phi_t                s2_phi_q;
  logic [evu_pkg::NumAxes-1:0]  s2_used_q;
  evu_pkg::axis_t               s2_mx_q;
  logic [evu_pkg::ProdW-1:0]    s2_t2_q, s2_t3_q;
  logic                         s2_hit;

  // Stage 3: squared terms.
  logic                         s3_valid_q;
  evu_pkg::phi_t                s3_phi_q;
  logic [evu_pkg::NumAxes-1:0]  s3_used_q;
  evu_pkg::axis_t               s3_mx_q;
  logic                         s3_hit_q;
  logic [evu_pkg::ProdW-1:0]    s3_sq2_q, s3_sq3_q;
  logic [evu_pkg::ProdW:0]      s3_sum;
  logic                         s3_drop;
  evu_pkg::phi_t                s3_phi;
  logic [evu_pkg::NumAxes-1:0]  s3_used;
  logic                         s3_two;
  evu_pkg::axis_t               s3_i, s3_j, s3_m, s3_k, s3_wa;

  // Stage 4: two-axis test term.
  logic                         s4_valid_q;
  evu_pkg::phi_t                s4_phi_q;
  logic [evu_pkg::NumAxes-1:0]  s4_used_q;
  logic                         s4_two_q;
  evu_pkg::axis_t               s4_m_q;
  logic [evu_pkg::ProdW-1:0]    s4_t_q;

  assign adv        = !(s4_valid_q && !cand_ready_i);
  assign in_i.ready = adv;

  always_comb begin
    for (int k = 0; k < evu_pkg::NumAxes; k++) begin
      if (s1_acc_q[2*k] && s1_acc_q[2*k+1]) begin
        s1_phi[k] = (s1_dist_q[2*k+1] < s1_dist_q[2*k]) ? s1_dist_q[2*k+1] : s1_dist_q[2*k];
      end else if (s1_acc_q[2*k]) begin
        s1_phi[k] = s1_dist_q[2*k];
      end else if (s1_acc_q[2*k+1]) begin
        s1_phi[k] = s1_dist_q[2*k+1];
      end else begin
        s1_phi[k] = '0;
      end
      s1_used[k] = s1_acc_q[2*k] | s1_acc_q[2*k+1];
    end
    // Largest axis; ties go to x, then y.
    if (s1_phi[0] >= s1_phi[1] && s1_phi[0] >= s1_phi[2]) begin
      s1_mx = 2'd0; s1_i = 2'd1; s1_j = 2'd2;
    end else if (s1_phi[1] >= s1_phi[0] && s1_phi[1] >= s1_phi[2]) begin
      s1_mx = 2'd1; s1_i = 2'd0; s1_j = 2'd2;
    end else begin
      s1_mx = 2'd2; s1_i = 2'd0; s1_j = 2'd1;
    end
  end

  assign s2_hit = (s2_t2_q > evu_pkg::OneQ32) || (s2_t3_q > evu_pkg::OneQ32)
               || ((s2_t2_q == evu_pkg::OneQ32) && (s2_t3_q != '0))
               || ((s2_t3_q == evu_pkg::OneQ32) && (s2_t2_q != '0));

  always_comb begin
    s3_sum  = {1'b0, s3_sq2_q} + {1'b0, s3_sq3_q};
    s3_drop = (&s3_used_q) && (s3_hit_q || (s3_sum > evu_pkg::OneQ64));
    s3_phi  = s3_phi_q;
    s3_used = s3_used_q;
    if (s3_drop) begin
      s3_phi[s3_mx_q]  = '0;
      s3_used[s3_mx_q] = 1'b0;
    end
    s3_two = (s3_used == 3'b011) || (s3_used == 3'b101) || (s3_used == 3'b110);
    if (!s3_used[0]) begin
      s3_i = 2'd1; s3_j = 2'd2;
    end else if (!s3_used[1]) begin
      s3_i = 2'd0; s3_j = 2'd2;
    end else begin
      s3_i = 2'd0; s3_j = 2'd1;
    end
    if (s3_phi[s3_i] >= s3_phi[s3_j]) begin
      s3_m = s3_i; s3_k = s3_j;
    end else begin
      s3_m = s3_j; s3_k = s3_i;
    end
    // The test weight follows the larger axis only when x is in use.
    s3_wa = s3_used[0] ? s3_m : s3_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dist_q <= {in_i.dist_z_minus, in_i.dist_z_plus, in_i.dist_y_minus,
                    in_i.dist_y_plus, in_i.dist_x_minus, in_i.dist_x_plus};
      s1_acc_q  <= {in_i.accepted_z_minus, in_i.accepted_z_plus, in_i.accepted_y_minus,
                    in_i.accepted_y_plus, in_i.accepted_x_minus, in_i.accepted_x_plus};

      s2_phi_q  <= s1_phi;
      s2_used_q <= s1_used;
      s2_mx_q   <= s1_mx;
      s2_t2_q   <= evu_pkg::mul_u32(evu_pkg::abs_diff(s1_phi[s1_mx], s1_phi[s1_i]),
                                    weights_i[s1_i]);
      s2_t3_q   <= evu_pkg::mul_u32(evu_pkg::abs_diff(s1_phi[s1_mx], s1_phi[s1_j]),
                                    weights_i[s1_j]);

      s3_phi_q  <= s2_phi_q;
      s3_used_q <= s2_used_q;
      s3_mx_q   <= s2_mx_q;
      s3_hit_q  <= s2_hit;
      s3_sq2_q  <= evu_pkg::mul_u32(s2_t2_q[31:0], s2_t2_q[31:0]);
      s3_sq3_q  <= evu_pkg::mul_u32(s2_t3_q[31:0], s2_t3_q[31:0]);

      s4_phi_q  <= s3_phi;
      s4_used_q <= s3_used;
      s4_two_q  <= s3_two;
      s4_m_q    <= s3_m;
      s4_t_q    <= evu_pkg::mul_u32(evu_pkg::abs_diff(s3_phi[s3_m], s3_phi[s3_k]),
                                    weights_i[s3_wa]);
    end
  end

  always_comb begin
    cand_o.phi  = s4_phi_q;
    cand_o.used = s4_used_q;
    if (s4_two_q && (s4_t_q > evu_pkg::OneQ32)) begin
      cand_o.phi[s4_m_q]  = '0;
      cand_o.used[s4_m_q] = 1'b0;
    end
  end

  assign cand_valid_o = s4_valid_q;

endmodule

/* hdl/evu_back.sv */
// Back end: sums, discriminant, pipelined square root and divider.
`timescale 1ns / 1ps

module evu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  evu_pkg::weights_t weights_i,
  input  logic              cand_valid_i,
  input  evu_pkg::cand_t    cand_i,
  output logic              cand_ready_o,
  evu_out_if.source         out_o
);

  typedef struct packed {
    logic [evu_pkg::SumW-1:0] s;
    logic [evu_pkg::BW-1:0]   b;
    evu_pkg::status_e         status;
  } ctx_t;

  logic adv;
  logic out_valid_q;

  // Stage A: popped candidate.
  logic           ba_valid_q;
  evu_pkg::cand_t ba_cand_q;
  logic [evu_pkg::SumW-1:0]                         a_s;
  logic [evu_pkg::NumAxes-1:0][evu_pkg::ProdW-1:0]  a_pw, a_ww, a_dd;
  logic [evu_pkg::NumAxes-1:0]                      a_en;

  // Stage B: first products.
  logic                                             bb_valid_q;
  logic [evu_pkg::SumW-1:0]                         bb_s_q;
  logic [evu_pkg::NumAxes-1:0][evu_pkg::ProdW-1:0]  bb_pw_q, bb_ww_q, bb_dd_q;
  logic [evu_pkg::NumAxes-1:0]                      bb_en_q;
  evu_pkg::status_e                                 bb_status_q;

  // Stage C: partial products of the pair terms.
  logic                                                   bc_valid_q;
  logic [evu_pkg::SumW-1:0]                               bc_s_q;
  logic [evu_pkg::BW-1:0]                                 bc_b_q;
  logic [evu_pkg::NumAxes-1:0][3:0][evu_pkg::ProdW-1:0]   bc_pp_q;
  logic [evu_pkg::NumAxes-1:0]                            bc_en_q;
  evu_pkg::status_e                                       bc_status_q;
  logic [evu_pkg::NumAxes-1:0][evu_pkg::PairW-1:0]        c_pair;

  // Stage D: pair terms; stage E: pair sum.
  logic                                             bd_valid_q;
  ctx_t                                             bd_ctx_q;
  logic [evu_pkg::NumAxes-1:0][evu_pkg::PairW-1:0]  bd_pair_q;
  logic                                             be_valid_q;
  ctx_t                                             be_ctx_q;
  logic [evu_pkg::PairSumW-1:0]                     be_pairs_q;
  logic [evu_pkg::PairSumW:0]                       e_diff;
  ctx_t                                             e_ctx;

  // Square root and divider stages.
  logic [evu_pkg::RootW:0]   sq_valid_q;
  logic [evu_pkg::DiscW-1:0] sq_rem_q  [evu_pkg::RootW+1];
  logic [evu_pkg::RootW-1:0] sq_root_q [evu_pkg::RootW+1];
  ctx_t                      sq_ctx_q  [evu_pkg::RootW+1];
  logic [evu_pkg::QuotW:0]   dv_valid_q;
  logic [evu_pkg::NumW-1:0]  dv_rem_q  [evu_pkg::QuotW+1];
  logic [evu_pkg::QuotW-1:0] dv_quo_q  [evu_pkg::QuotW+1];
  ctx_t                      dv_ctx_q  [evu_pkg::QuotW+1];

  logic [evu_pkg::DistW-1:0] out_dist_q;
  evu_pkg::status_e          out_status_q;

  assign adv          = !out_valid_q || out_o.ready;
  assign cand_ready_o = adv;

  always_comb begin
    a_s = '0;
    for (int k = 0; k < evu_pkg::NumAxes; k++) begin
      if (ba_cand_q.used[k]) begin
        a_s = a_s + evu_pkg::SumW'(weights_i[k]);
      end
      a_pw[k] = ba_cand_q.used[k] ? evu_pkg::mul_u32(ba_cand_q.phi[k], weights_i[k]) : '0;
    end
    for (int p = 0; p < evu_pkg::NumAxes; p++) begin
      a_en[p] = ba_cand_q.used[evu_pkg::pair_lo(2'(p))] && ba_cand_q.used[evu_pkg::pair_hi(2'(p))];
      a_ww[p] = evu_pkg::mul_u32(weights_i[evu_pkg::pair_lo(2'(p))],
                                 weights_i[evu_pkg::pair_hi(2'(p))]);
      a_dd[p] = evu_pkg::mul_u32(
          evu_pkg::abs_diff(ba_cand_q.phi[evu_pkg::pair_lo(2'(p))],
                            ba_cand_q.phi[evu_pkg::pair_hi(2'(p))]),
          evu_pkg::abs_diff(ba_cand_q.phi[evu_pkg::pair_lo(2'(p))],
                            ba_cand_q.phi[evu_pkg::pair_hi(2'(p))]));
    end
  end

  // A 64 by 64 pair product reassembled from its four 32 by 32 pieces.
  always_comb begin
    for (int p = 0; p < evu_pkg::NumAxes; p++) begin
      c_pair[p] = {bc_pp_q[p][3], 64'h0}
                + {31'h0, ({1'b0, bc_pp_q[p][1]} + {1'b0, bc_pp_q[p][2]}), 32'h0}
                + {64'h0, bc_pp_q[p][0]};
      if (!bc_en_q[p]) begin
        c_pair[p] = '0;
      end
    end
  end

  // The discriminant goes negative exactly when the subtraction borrows.
  always_comb begin
    e_diff = {49'h0, be_ctx_q.s, 48'h0} - {1'b0, be_pairs_q};
    e_ctx  = be_ctx_q;
    if (be_ctx_q.status == evu_pkg::StatusUpdated && e_diff[evu_pkg::PairSumW]) begin
      e_ctx.status = evu_pkg::StatusNegDisc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ba_cand_q   <= cand_i;

      bb_s_q      <= a_s;
      bb_pw_q     <= a_pw;
      bb_ww_q     <= a_ww;
      bb_dd_q     <= a_dd;
      bb_en_q     <= a_en;
      bb_status_q <= (ba_cand_q.used == '0) ? evu_pkg::StatusNoNeighbour
                                            : evu_pkg::StatusUpdated;

      bc_s_q      <= bb_s_q;
      bc_b_q      <= {2'b00, bb_pw_q[0]} + {2'b00, bb_pw_q[1]} + {2'b00, bb_pw_q[2]};
      bc_en_q     <= bb_en_q;
      bc_status_q <= bb_status_q;
      for (int p = 0; p < evu_pkg::NumAxes; p++) begin
        bc_pp_q[p][0] <= evu_pkg::mul_u32(bb_ww_q[p][31:0],  bb_dd_q[p][31:0]);
        bc_pp_q[p][1] <= evu_pkg::mul_u32(bb_ww_q[p][31:0],  bb_dd_q[p][63:32]);
        bc_pp_q[p][2] <= evu_pkg::mul_u32(bb_ww_q[p][63:32], bb_dd_q[p][31:0]);
        bc_pp_q[p][3] <= evu_pkg::mul_u32(bb_ww_q[p][63:32], bb_dd_q[p][63:32]);
      end

      bd_ctx_q.s      <= bc_s_q;
      bd_ctx_q.b      <= bc_b_q;
      bd_ctx_q.status <= bc_status_q;
      bd_pair_q       <= c_pair;

      be_ctx_q   <= bd_ctx_q;
      be_pairs_q <= {2'b00, bd_pair_q[0]} + {2'b00, bd_pair_q[1]} + {2'b00, bd_pair_q[2]};

      sq_ctx_q[0]  <= e_ctx;
      sq_rem_q[0]  <= (e_ctx.status == evu_pkg::StatusUpdated) ? e_diff[evu_pkg::DiscW-1:0]
                                                               : '0;
      sq_root_q[0] <= '0;

      dv_ctx_q[0]  <= sq_ctx_q[evu_pkg::RootW];
      dv_rem_q[0]  <= evu_pkg::NumW'(sq_ctx_q[evu_pkg::RootW].b)
                    + evu_pkg::NumW'(sq_root_q[evu_pkg::RootW]);
      dv_quo_q[0]  <= '0;

      out_dist_q   <= (dv_ctx_q[evu_pkg::QuotW].status == evu_pkg::StatusUpdated)
                      ? dv_quo_q[evu_pkg::QuotW] : '0;
      out_status_q <= dv_ctx_q[evu_pkg::QuotW].status;
    end
  end

  // One root bit per stage, most significant first.
  for (genvar n = 0; n < evu_pkg::RootW; n++) begin : g_sqrt
    localparam int unsigned K = evu_pkg::RootW - 1 - n;
    logic [evu_pkg::DiscW:0] trial;
    logic                    take;

    always_comb begin
      trial = ({{(evu_pkg::DiscW + 1 - evu_pkg::RootW){1'b0}}, sq_root_q[n]} << (K + 1))
            | ((evu_pkg::DiscW + 1)'(1) << (2 * K));
      take  = ({1'b0, sq_rem_q[n]} >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[n+1]  <= take ? sq_rem_q[n] - trial[evu_pkg::DiscW-1:0] : sq_rem_q[n];
        sq_root_q[n+1] <= take ? (sq_root_q[n] | (evu_pkg::RootW'(1) << K)) : sq_root_q[n];
        sq_ctx_q[n+1]  <= sq_ctx_q[n];
      end
    end
  end

  // One quotient bit per stage; a zero weight sum saturates every bit.
  for (genvar n = 0; n < evu_pkg::QuotW; n++) begin : g_div
    localparam int unsigned K = evu_pkg::QuotW - 1 - n;
    logic [evu_pkg::NumW-1:0] shifted;
    logic                     take;

    always_comb begin
      shifted = evu_pkg::NumW'(dv_ctx_q[n].s) << K;
      take    = (shifted <= dv_rem_q[n]);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[n+1] <= take ? dv_rem_q[n] - shifted : dv_rem_q[n];
        dv_quo_q[n+1] <= take ? (dv_quo_q[n] | (evu_pkg::QuotW'(1) << K)) : dv_quo_q[n];
        dv_ctx_q[n+1] <= dv_ctx_q[n];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ba_valid_q  <= 1'b0;
      bb_valid_q  <= 1'b0;
      bc_valid_q  <= 1'b0;
      bd_valid_q  <= 1'b0;
      be_valid_q  <= 1'b0;
      sq_valid_q  <= '0;
      dv_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      ba_valid_q  <= cand_valid_i;
      bb_valid_q  <= ba_valid_q;
      bc_valid_q  <= bb_valid_q;
      bd_valid_q  <= bc_valid_q;
      be_valid_q  <= bd_valid_q;
      sq_valid_q  <= {sq_valid_q[evu_pkg::RootW-1:0], be_valid_q};
      dv_valid_q  <= {dv_valid_q[evu_pkg::QuotW-1:0], sq_valid_q[evu_pkg::RootW]};
      out_valid_q <= dv_valid_q[evu_pkg::QuotW];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.new_distance = out_dist_q;
  assign out_o.status       = out_status_q;

endmodule

/* hdl/eikonal_voxel_update.sv */
// Top level of the eikonal voxel update block.
`timescale 1ns / 1ps
`include "eikonal_voxel_update_defines.svh"

// Eikonal voxel update: for each request of six face-neighbour distances with
// their accepted flags, the block returns one tentative distance (unsigned
// Q16.16, floor-rounded and saturated) and a status of updated, no accepted
// neighbour or negative discriminant. Non-updated results carry a distance of
// zero. A new request is taken every clock cycle unless the front end is
// blocked by a full queue. The solver holds the 41-stage square root and the
// 32-stage divider, each retiring one bit a stage. A front end of four stages
// picks the smaller distance on each axis and prunes axes; a queue of
// QueueDepth entries then feeds the solver, so an output that is held back
// only stalls the solver while requests keep being taken until the queue
// fills. The three inverse squared spacing registers are written over the
// configuration channel, which is always ready; they must only be changed
// while no request is in flight. Writes to index three are ignored.
module eikonal_voxel_update #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  evu_in_if.sink    in_i,
  evu_out_if.source out_o,
  evu_cfg_if.sink   cfg_i
);

  evu_pkg::weights_t weights_q;

  logic           front_valid;
  evu_pkg::cand_t front_cand;
  logic           queue_ready;
  logic           queue_valid;
  evu_pkg::cand_t queue_cand;
  logic           back_ready;

  // Configuration writes land directly in the weight registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q[0] <= evu_pkg::WgtReset;
      weights_q[1] <= evu_pkg::WgtReset;
      weights_q[2] <= evu_pkg::WgtReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        evu_pkg::CfgInvSqSpacingX: weights_q[0] <= cfg_i.data;
        evu_pkg::CfgInvSqSpacingY: weights_q[1] <= cfg_i.data;
        evu_pkg::CfgInvSqSpacingZ: weights_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  evu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .weights_i    (weights_q),
    .cand_valid_o (front_valid),
    .cand_o       (front_cand),
    .cand_ready_i (queue_ready)
  );

  evu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cand),
    .ready_o (queue_ready),
    .valid_o (queue_valid),
    .data_o  (queue_cand),
    .pop_i   (back_ready)
  );

  evu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .weights_i    (weights_q),
    .cand_valid_i (queue_valid),
    .cand_i       (queue_cand),
    .cand_ready_o (back_ready),
    .out_o        (out_o)
  );

  // A result that is not an update never carries a distance.
  `EVU_ASSERT_IMP(a_status_zero, out_o.valid && (out_o.status != evu_pkg::StatusUpdated), out_o.new_distance == '0, "non-update result with nonzero distance")

  // Requests are refused only while the front end is blocked by a full queue.
  `EVU_ASSERT_IMP(a_ready_low_queue_full, !in_i.ready, front_valid && !queue_ready, "request refused while queue has room")

  // A held result freezes the solver, so the queue cannot drain.
  `EVU_ASSERT_IMP(a_stall_freezes_back, out_o.valid && !out_o.ready, !back_ready, "solver advanced while result held")

  // A write to the y spacing register takes effect on the next edge.
  `EVU_ASSERT_NEXT(a_cfg_y_write, cfg_i.valid && cfg_i.ready && (cfg_i.index == evu_pkg::CfgInvSqSpacingY), weights_q[1] == $past(cfg_i.data), "y spacing register not written")

endmodule
